@@ rtl/core/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PHE_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("phe check failed");

// next-cycle implication
`define PHE_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("phe check failed");

`endif

@@ rtl/core/phe_pkg.sv @@
package phe_pkg;

  localparam int ELEM_W = 63;
  localparam int HASH_W = 64;
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0]  CNT_TOP  = 6'd63;
  localparam logic [ELEM_W-1:0] BASE_RST = 63'd1000009;
  localparam logic [ELEM_W-1:0] MOD_RST  = 63'd998244353;

  // configuration register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_MOD  = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED_E = 9'b000000010,
    S_RED_B = 9'b000000100,
    S_RED_P = 9'b000001000,
    S_RED_S = 9'b000010000,
    S_MUL_E = 9'b000100000,
    S_ADD   = 9'b001000000,
    S_MUL_B = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  // sequencer to datapath control
  typedef struct packed {
    state_t           st;
    logic [CNT_W-1:0] cnt;
    logic             first;
    logic             fin_step;
    logic             emit;
    logic             done;
  } ctl_t;

endpackage

@@ rtl/core/phe_alu.sv @@
// shared modular double-and-add step:
// res = ((dbl ? 2*acc : acc) + (add_en ? a : 0)) mod m, or mod 2^64 when wrap
module phe_alu (
  input  logic [phe_pkg::HASH_W-1:0] acc,
  input  logic [phe_pkg::HASH_W-1:0] a,
  input  logic                       add_en,
  input  logic                       dbl,
  input  logic                       wrap,
  input  logic [phe_pkg::ELEM_W-1:0] mod_val,
  output logic [phe_pkg::HASH_W-1:0] res
);
  import phe_pkg::*;

  logic [HASH_W+1:0] x;
  logic [HASH_W+1:0] y;
  logic [HASH_W+1:0] sum;
  logic [HASH_W+1:0] m1;
  logic [HASH_W+1:0] m2;
  logic [HASH_W+1:0] d1;
  logic [HASH_W+1:0] d2;

  // operands, sum stays below 3m in modular use
  assign x   = dbl ? {1'b0, acc, 1'b0} : {2'b00, acc};
  assign y   = add_en ? {2'b00, a} : '0;
  assign sum = x + y;
  assign m1  = {3'b000, mod_val};
  assign m2  = {2'b00, mod_val, 1'b0};
  assign d1  = sum - m1;
  assign d2  = sum - m2;

  // pick the reduced value
  always_comb begin
    if (wrap) begin
      res = sum[HASH_W-1:0];
    end else if (sum >= m2) begin
      res = d2[HASH_W-1:0];
    end else if (sum >= m1) begin
      res = d1[HASH_W-1:0];
    end else begin
      res = sum[HASH_W-1:0];
    end
  end

endmodule

@@ rtl/core/phe_ctrl.sv @@
`include "assert_macros.svh"

// sequencer: walks reduce (skipped when wrap), multiply and add phases, one bit step per cycle
module phe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          wrap,
  input  logic          last_pend,
  input  logic          out_free,
  output logic          in_ready,
  output phe_pkg::ctl_t ctl
);
  import phe_pkg::*;

  state_t           st_r;
  state_t           st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             iter;
  logic             fin_step;
  logic             done;

  assign iter = (st_r == S_RED_E) || (st_r == S_RED_B) || (st_r == S_RED_P) ||
                (st_r == S_RED_S) || (st_r == S_MUL_E) || (st_r == S_MUL_B);
  assign fin_step = iter && (cnt_r == '0);
  assign done     = (st_r == S_FIN) && (!last_pend || out_free);
  assign in_ready = (st_r == S_IDLE);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_fire) st_nxt = wrap ? S_MUL_E : S_RED_E;
      S_RED_E: if (fin_step) st_nxt = S_RED_B;
      S_RED_B: if (fin_step) st_nxt = S_RED_P;
      S_RED_P: if (fin_step) st_nxt = S_RED_S;
      S_RED_S: if (fin_step) st_nxt = S_MUL_E;
      S_MUL_E: if (fin_step) st_nxt = S_ADD;
      S_ADD:   st_nxt = S_MUL_B;
      S_MUL_B: if (fin_step) st_nxt = S_FIN;
      S_FIN:   if (done) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // bit index, msb first, parked at the top between phases
  assign cnt_nxt = iter ? cnt_r - 1'b1 : CNT_TOP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= CNT_TOP;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    ctl.st       = st_r;
    ctl.cnt      = cnt_r;
    ctl.first    = (cnt_r == CNT_TOP);
    ctl.fin_step = fin_step;
    ctl.emit     = done && last_pend;
    ctl.done     = done;
  end

  `PHE_ASSERT_NXT(a_start_phase, in_fire, st_r == S_RED_E || st_r == S_MUL_E)
  `PHE_ASSERT_IMP(a_cnt_parked, st_r == S_ADD || st_r == S_IDLE, cnt_r == CNT_TOP)
  `PHE_ASSERT_NXT(a_phase_wrap, fin_step && st_r != S_MUL_B, cnt_r == CNT_TOP && iter || st_r == S_ADD)

endmodule

@@ rtl/core/polynomial_hash_engine_unit.sv @@
`include "assert_macros.svh"

// Polynomial hash engine: folds a stream of 63-bit elements into
// hash = sum element[i] * base^i, exact modulo the modulus register or
// wrapping modulo 2^64 when the modulus is zero; a beat with tlast set
// closes the sequence, emits the hash and restarts at sum 0, power 1.
// All arithmetic runs through one shared double-and-add step that handles
// one multiplier bit per cycle. With a nonzero modulus an element passes
// through reductions of element, base, power and sum, a modular multiply
// of power by element, an add into the sum, a modular multiply of power by
// base, a finish state and the idle state before the next ready; with
// modulus zero the reductions are skipped. The input is held off while an
// element is in work; a finished hash waits in the output register while
// the next element runs; the finish stalls only if that register is full.
module polynomial_hash_engine_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beat
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,   // [62:0] element, [63] zero
  input  logic                       in_tlast,
  // result beat
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,  // [63:0] hash
  // configuration writes
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [phe_pkg::ELEM_W-1:0] cfg_wdata
);
  import phe_pkg::*;

  ctl_t              ctl;
  logic              in_fire;
  logic              wrap;
  logic              out_free;
  logic [ELEM_W-1:0] base_r;
  logic [ELEM_W-1:0] mod_r;
  logic [HASH_W-1:0] e_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] p_r;
  logic [HASH_W-1:0] s_r;
  logic [HASH_W-1:0] acc_r;
  logic              last_r;
  logic [HASH_W-1:0] hash_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] alu_acc;
  logic [HASH_W-1:0] alu_a;
  logic              alu_add;
  logic              alu_dbl;
  logic [HASH_W-1:0] alu_res;
  logic [HASH_W-1:0] bit_src;

  assign in_fire    = in_tvalid && in_tready;
  assign wrap       = (mod_r == '0);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = hash_r;

  phe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .wrap      (wrap),
    .last_pend (last_r),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .ctl       (ctl)
  );

  // operand selection for the shared step
  always_comb begin
    bit_src = e_r;
    alu_a   = {{(HASH_W-1){1'b0}}, 1'b1};
    alu_acc = ctl.first ? '0 : acc_r;
    alu_dbl = 1'b1;
    case (ctl.st)
      S_RED_E: bit_src = e_r;
      S_RED_B: bit_src = b_r;
      S_RED_P: bit_src = p_r;
      S_RED_S: bit_src = s_r;
      S_MUL_E: begin
        bit_src = e_r;
        alu_a   = p_r;
      end
      S_MUL_B: begin
        bit_src = b_r;
        alu_a   = p_r;
      end
      S_ADD: begin
        alu_acc = s_r;
        alu_a   = acc_r;
        alu_dbl = 1'b0;
      end
      default: bit_src = e_r;
    endcase
    alu_add = (ctl.st == S_ADD) ? 1'b1 : bit_src[ctl.cnt];
  end

  phe_alu u_alu (
    .acc     (alu_acc),
    .a       (alu_a),
    .add_en  (alu_add),
    .dbl     (alu_dbl),
    .wrap    (wrap),
    .mod_val (mod_r),
    .res     (alu_res)
  );

  // configuration, running state and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RST;
      mod_r       <= MOD_RST;
      s_r         <= '0;
      p_r         <= {{(HASH_W-1){1'b0}}, 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == CFG_BASE) base_r <= cfg_wdata;
      if (cfg_we && cfg_addr == CFG_MOD)  mod_r  <= cfg_wdata;
      if (ctl.fin_step && (ctl.st == S_RED_P || ctl.st == S_MUL_B)) p_r <= alu_res;
      if ((ctl.fin_step && ctl.st == S_RED_S) || ctl.st == S_ADD) s_r <= alu_res;
      if (ctl.emit) begin
        s_r <= '0;
        p_r <= {{(HASH_W-1){1'b0}}, 1'b1};
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_r    <= {1'b0, in_tdata[ELEM_W-1:0]};
      b_r    <= {1'b0, base_r};
      last_r <= in_tlast;
    end else begin
      if (ctl.fin_step && ctl.st == S_RED_E) e_r <= alu_res;
      if (ctl.fin_step && ctl.st == S_RED_B) b_r <= alu_res;
    end
    if (ctl.st != S_IDLE && ctl.st != S_FIN) acc_r <= alu_res;
    if (ctl.emit) hash_r <= s_r;
  end

  `PHE_ASSERT_IMP(a_reduced, !wrap && ctl.fin_step, alu_res < {1'b0, mod_r})
  `PHE_ASSERT_NXT(a_restart, ctl.emit, s_r == '0 && p_r == 64'd1 && out_valid_r)
  `PHE_ASSERT_IMP(a_emit_free, ctl.emit, out_free && last_r)

endmodule

@@ sim/polynomial_hash_engine_unit_test.sv @@
module polynomial_hash_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import phe_pkg::*;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {ELEM_W{1'b1}};
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int DRAIN_CYCLES = 400;   // a little longer than one element takes in the block
  localparam int HOLD_CYCLES  = 2500;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_BEATS  = 100;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last;
  } elem_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata = '0;   // [62:0] element, [63] zero
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [63:0]       out_tdata;       // [63:0] hash
  logic              cfg_we = 1'b0;
  logic              cfg_addr = CFG_BASE;
  logic [ELEM_W-1:0] cfg_wdata = '0;

  polynomial_hash_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the configuration and the hash accumulator
  logic [ELEM_W-1:0] base_reg = BASE_RST;
  logic [ELEM_W-1:0] mod_reg  = MOD_RST;
  logic [63:0]       acc_sum   = 64'd0;
  logic [63:0]       acc_power = 64'd1;

  elem_beat_t  pending_beats[$];
  logic [63:0] expected_hashes[$];

  int cycle_count = 0;
  int in_beats    = 0;
  int hashes_seen = 0;
  int errors      = 0;

  // exact (a * b) mod m through a double-width product
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod % {64'd0, m};
    return prod[63:0];
  endfunction

  // fold one accepted element into the accumulator
  task automatic fold_element(logic [ELEM_W-1:0] element, logic last);
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] b;
    logic [63:0] p;
    logic [63:0] s;
    if (mod_reg != '0) begin
      m = {1'b0, mod_reg};
      e = {1'b0, element} % m;
      b = {1'b0, base_reg} % m;
      p = acc_power % m;
      s = acc_sum % m;
      s = s + mul_mod(p, e, m);
      if (s >= m) s = s - m;
      p = mul_mod(p, b, m);
    end else begin
      s = acc_sum + acc_power * {1'b0, element};
      p = acc_power * {1'b0, base_reg};
    end
    if (last) begin
      expected_hashes = {expected_hashes, s};
      s = 64'd0;
      p = 64'd1;
    end
    acc_sum   = s;
    acc_power = p;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s, got %h, want %h", cycle_count, what, got, want);
    errors++;
  endtask

  // monitor: input beats feed the accumulator, hash beats are checked in order
  always @(posedge clk) begin : watch_ports
    logic [63:0] want;
    cycle_count++;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_beats++;
        fold_element(in_tdata[ELEM_W-1:0], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        hashes_seen++;
        if (expected_hashes.size() == 0) begin
          report_mismatch("hash with none pending", out_tdata, 64'd0);
        end else begin
          want = expected_hashes.pop_front();
          if (out_tdata !== want) report_mismatch("hash", out_tdata, want);
        end
      end
    end
  end

  // driver: bursts of element beats separated by random gaps
  int beats_seen = 0;
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin : feed_elements
    elem_beat_t nxt;
    logic       taken;
    logic       offer;
    taken = (in_beats != beats_seen);
    beats_seen = in_beats;
    if (!in_tvalid || taken) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        in_tdata <= {1'b0, nxt.element};
        in_tlast <= nxt.last;
        offer = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(20, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
          end
        end
      end
      in_tvalid <= offer;
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs now and then
  int hold_left    = 0;
  int next_hold_at = 30;
  int rx_mode      = 0;
  int mode_left    = 0;

  always @(negedge clk) begin : drain_hashes
    logic rdy;
    rdy = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (hashes_seen >= next_hold_at) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at = next_hold_at + 90;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 1500);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1) == 1;
        2: rdy = $urandom_range(0, 7) == 0;
        default: rdy = $urandom_range(0, 3) != 0;
      endcase
    end
    out_tready <= rdy;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("polynomial_hash_engine_unit_test: done, errors");
    $finish;
  end

  function automatic logic [ELEM_W-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ELEM_W-1:0];
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element(logic [ELEM_W-1:0] m);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ELEM_MAX;
      2: return m - 1'b1;
      3: return m;
      4: return ELEM_W'($urandom_range(0, 255));
      default: return rand63();
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] pick_base();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ELEM_W'(1);
      2: return ELEM_W'(2);
      3: return ELEM_MAX;
      4: return ELEM_W'($urandom_range(0, 1000));
      default: return rand63();
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] pick_modulus();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ELEM_W'(1);
      2: return ELEM_W'($urandom_range(2, 1000));
      3: return ELEM_W'($urandom);
      4: return ELEM_MAX;
      default: return rand63();
    endcase
  endfunction

  task automatic push_beat(logic [ELEM_W-1:0] element, logic last);
    elem_beat_t bt;
    bt.element = element;
    bt.last    = last;
    pending_beats = {pending_beats, bt};
  endtask

  // wait until every beat is taken and every expected hash is back
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || expected_hashes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ELEM_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE) base_reg = value;
    else mod_reg = value;
  endtask

  // new settings once the block has gone quiet, even mid-sequence
  task automatic set_phase(logic [ELEM_W-1:0] base, logic [ELEM_W-1:0] m);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(CFG_BASE, base);
    write_reg(CFG_MOD, m);
  endtask

  // sequences of random length; the phase may stop inside one
  task automatic queue_sequences(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      for (int k = 0; k < len && n < count; k++) begin
        push_beat(pick_element(mod_reg), k == len - 1);
        n++;
      end
    end
  endtask

  initial begin : stimulus
    logic [ELEM_W-1:0] b;
    logic [ELEM_W-1:0] m;
    rst_n <= 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, element equal to modulus, short chain
    push_beat(ELEM_MAX, 1'b1);
    push_beat('0, 1'b1);
    push_beat(ELEM_W'(1), 1'b0);
    push_beat(ELEM_W'(2), 1'b0);
    push_beat(ELEM_W'(3), 1'b1);
    push_beat(MOD_RST, 1'b1);
    push_beat(MOD_RST - 1'b1, 1'b1);

    // zero modulus wraps; leave a sequence open with a large sum
    set_phase(ELEM_MAX, '0);
    push_beat(ELEM_MAX, 1'b0);
    push_beat(ELEM_MAX, 1'b0);
    push_beat(ELEM_MAX, 1'b1);
    push_beat(ELEM_MAX, 1'b0);
    push_beat(ELEM_W'(123), 1'b0);

    // modulus switched mid-sequence, base zero
    set_phase('0, ELEM_MAX);
    push_beat(ELEM_MAX, 1'b0);
    push_beat(ELEM_W'(1), 1'b1);

    // modulus one gives hash zero; open sequence again
    set_phase(ELEM_W'(12345), ELEM_W'(1));
    push_beat(ELEM_W'(5), 1'b0);
    push_beat(ELEM_MAX, 1'b1);
    push_beat(ELEM_W'(9), 1'b0);

    // back to zero modulus with the stored state
    set_phase('0, '0);
    push_beat(ELEM_W'(3), 1'b1);

    // base far above a tiny modulus
    set_phase(ELEM_MAX, ELEM_W'(2));
    push_beat(ELEM_W'(1), 1'b0);
    push_beat(ELEM_W'(1), 1'b0);
    push_beat(ELEM_W'(1), 1'b1);

    // random phases, extremes first
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin b = ELEM_MAX; m = ELEM_MAX; end
        1: begin b = '0;       m = '0;       end
        2: begin b = ELEM_MAX; m = '0;       end
        3: begin b = rand63(); m = ELEM_W'(1); end
        4: begin b = rand63(); m = ELEM_W'(2); end
        5: begin b = BASE_RST; m = MOD_RST;  end
        default: begin b = pick_base(); m = pick_modulus(); end
      endcase
      set_phase(b, m);
      queue_sequences(PHASE_BEATS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_hashes.size() == 0) begin
      $display("polynomial_hash_engine_unit_test: done, clean");
    end else begin
      $display("polynomial_hash_engine_unit_test: done, errors");
    end
    $finish;
  end

endmodule
